// ----- rtl/gnms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared types, constants and the angle sector classifier for the gradient
// non-maximum suppression block.
// ----------------------------------------------------------------------------
package gnms_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_HEIGHT        = 4096;
   localparam int WIDTH_RESET       = 640;
   localparam int HEIGHT_RESET      = 480;

   localparam int MAG_W        = 16;
   localparam int ANG_W        = 16;
   localparam int EDGE_W       = 8;
   localparam int HGT_W        = 13;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 16;
   localparam int OUT_DEPTH    = 4;

   localparam logic [ANG_W-1:0]  ANG_22_5  = 16'd3216;
   localparam logic [ANG_W-1:0]  ANG_67_5  = 16'd9650;
   localparam logic [ANG_W-1:0]  ANG_112_5 = 16'd16084;
   localparam logic [ANG_W-1:0]  ANG_157_5 = 16'd22518;
   localparam logic [EDGE_W-1:0] SAT_MAX   = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH  = 4'd0,
      REG_FRAME_HEIGHT = 4'd1
   } reg_index_type;

   typedef enum logic [1:0] {
      SEC_HORIZ = 2'd0,
      SEC_DIAG  = 2'd1,
      SEC_VERT  = 2'd2,
      SEC_ANTI  = 2'd3
   } sector_type;

   typedef struct packed {
      logic [EDGE_W-1:0] edge_value;
      logic              frame_last;
   } rsp_type;

   typedef struct packed {
      logic left;
      logic right;
      logic up;
      logic down;
   } nbr_type;

   function automatic sector_type classify(input logic [ANG_W-1:0] ang);
      logic             neg;
      logic [ANG_W-1:0] mag;
      sector_type       sec;
      neg = ang[ANG_W-1];
      mag = neg ? (~ang + 16'd1) : ang;
      if (mag <= ANG_22_5 || mag > ANG_157_5) begin
         sec = SEC_HORIZ;
      end else if (mag > ANG_67_5 && mag <= ANG_112_5) begin
         sec = SEC_VERT;
      end else if (mag <= ANG_67_5) begin
         sec = neg ? SEC_ANTI : SEC_DIAG;
      end else begin
         sec = neg ? SEC_DIAG : SEC_ANTI;
      end
      return sec;
   endfunction

endpackage

// ----- rtl/gnms_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnms_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module gnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gradient_non_max_suppression.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_non_max_suppression
// Canny-style non-maximum suppression over a raster stream of gradient
// magnitude and angle, with line stores held in one RAM.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_type, req_magnitude, req_angle
//  rsp      out        rsp_valid/rsp_stall   rsp_edge_value, rsp_frame_last
//  csr      in         csr_valid/csr_ready   csr_index, csr_data
//
//  one request per cycle while req_stall is low; each result is registered in the result queue
//  line store read at accept, read-modify-write of the same column in the
//  next cycle, back-to-back hits on one column are forwarded
//  4-entry result queue; req_stall rises when queue plus in-flight reaches 4
//  synchronous reset, no clearing pass; csr_ready is always high
// ----------------------------------------------------------------------------
module gradient_non_max_suppression #(
   parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [gnms_pkg::MAG_W-1:0]       req_magnitude,
   input  logic signed [gnms_pkg::ANG_W-1:0] req_angle,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [gnms_pkg::EDGE_W-1:0]      rsp_edge_value,
   output logic                             rsp_frame_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gnms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gnms_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int CNT_W   = COL_W + 1;
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W   = gnms_pkg::HGT_W;
   localparam int ROW_W   = HGT_W;
   localparam int MAG_W   = gnms_pkg::MAG_W;
   localparam int WORD_W  = 2 * MAG_W + 2;
   localparam int QPTR_W  = $clog2(gnms_pkg::OUT_DEPTH);
   localparam int QCNT_W  = QPTR_W + 1;
   localparam int WID_RST = (gnms_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : gnms_pkg::WIDTH_RESET;

   // configuration
   logic [WID_W-1:0] width_ff, width_in;
   logic [HGT_W-1:0] height_ff, height_in;
   logic             csr_fire;
   logic             csr_restart;
   logic [HGT_W-1:0] cfg_w_raw, cfg_h_raw;

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // accept stage
   logic                 req_fire, take, done, last_pos, emit_pos, col_nz, col_wrap;
   logic                 fwd_hit;
   gnms_pkg::nbr_type    nbr_now;
   gnms_pkg::sector_type sec_now;
   logic [MAG_W-1:0]     mag_now;

   // read-modify-write stage
   logic                 s1_v_ff;
   logic                 s1_emit_ff, s1_last_ff, s1_fwd_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic [MAG_W-1:0]     s1_mag_ff;
   gnms_pkg::sector_type s1_sec_ff;
   gnms_pkg::nbr_type    s1_nbr_ff;
   logic [WORD_W-1:0]    ram_rd_data, rd_word, wr_word, wb_ff;
   logic [MAG_W-1:0]     top_rd, mid_rd;
   gnms_pkg::sector_type sec_rd;

   // window
   logic [MAG_W-1:0]     win_ff [9];
   logic [MAG_W-1:0]     win_sh [9];
   gnms_pkg::sector_type centre_ff;

   // result
   logic [MAG_W-1:0]    n1, n2, centre;
   logic                v1, v2, suppress;
   gnms_pkg::rsp_type   result;
   logic                push, pop;

   // result queue
   gnms_pkg::rsp_type q_ff [gnms_pkg::OUT_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, rptr_ff;
   logic [QCNT_W-1:0] qcnt_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid & csr_ready;
   assign csr_restart = csr_fire & ((csr_index == gnms_pkg::REG_FRAME_WIDTH) |
                                    (csr_index == gnms_pkg::REG_FRAME_HEIGHT));
   assign cfg_w_raw   = HGT_W'(csr_data[gnms_pkg::CFG_WIDTH_W-1:0]);
   assign cfg_h_raw   = csr_data[HGT_W-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_fire) begin
         case (gnms_pkg::reg_index_type'(csr_index))
            gnms_pkg::REG_FRAME_WIDTH: begin
               if (cfg_w_raw == '0) begin
                  width_in = WID_W'(1);
               end else if (cfg_w_raw > HGT_W'(MAX_WIDTH)) begin
                  width_in = WID_W'(MAX_WIDTH);
               end else begin
                  width_in = WID_W'(cfg_w_raw);
               end
            end
            gnms_pkg::REG_FRAME_HEIGHT: begin
               if (cfg_h_raw == '0) begin
                  height_in = HGT_W'(1);
               end else if (cfg_h_raw > HGT_W'(gnms_pkg::MAX_HEIGHT)) begin
                  height_in = HGT_W'(gnms_pkg::MAX_HEIGHT);
               end else begin
                  height_in = cfg_h_raw;
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- accept
   assign req_stall = (qcnt_ff + QCNT_W'(s1_v_ff)) >= QCNT_W'(gnms_pkg::OUT_DEPTH);
   assign req_fire  = req_valid & ~req_stall;
   assign done      = row_ff >= height_ff;
   assign take      = req_fire & ~(req_type & ~done);
   assign col_nz    = col_ff != '0;
   assign col_wrap  = (CNT_W'(col_ff) + CNT_W'(1)) >= CNT_W'(width_ff);
   assign last_pos  = (HGT_W'(row_ff) == height_ff + HGT_W'(1)) && !col_nz;
   assign emit_pos  = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && col_nz);
   assign fwd_hit   = s1_v_ff && (s1_col_ff == col_ff);
   assign mag_now   = done ? '0 : req_magnitude;
   assign sec_now   = done ? gnms_pkg::SEC_HORIZ : gnms_pkg::classify(req_angle);

   always_comb begin
      nbr_now.right = col_nz;
      if (col_nz) begin
         nbr_now.left = col_ff >= COL_W'(2);
         nbr_now.up   = row_ff >= ROW_W'(2);
         nbr_now.down = row_ff < height_ff;
      end else begin
         nbr_now.left = width_ff >= WID_W'(2);
         nbr_now.up   = row_ff >= ROW_W'(3);
         nbr_now.down = row_ff <= height_ff;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (last_pos) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------- line store
   gnms_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_WIDTH)
   ) u_lines (
      .clock  (clock),
      .wr_en  (s1_v_ff),
      .wr_addr(s1_col_ff),
      .wr_data(wr_word),
      .rd_en  (take),
      .rd_addr(col_ff),
      .rd_data(ram_rd_data)
   );

   assign rd_word = s1_fwd_ff ? wb_ff : ram_rd_data;
   assign sec_rd  = gnms_pkg::sector_type'(rd_word[WORD_W-1 -: 2]);
   assign top_rd  = rd_word[2*MAG_W-1 -: MAG_W];
   assign mid_rd  = rd_word[MAG_W-1:0];
   assign wr_word = {s1_sec_ff, mid_rd, s1_mag_ff};

   // ---------------------------------------------------------------- window
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_sh[r*3]     = win_ff[r*3+1];
         win_sh[r*3 + 1] = win_ff[r*3+2];
      end
      win_sh[2] = top_rd;
      win_sh[5] = mid_rd;
      win_sh[8] = s1_mag_ff;
   end

   assign centre = win_sh[4];

   always_comb begin
      case (centre_ff)
         gnms_pkg::SEC_HORIZ: begin
            v1 = s1_nbr_ff.left;
            n1 = win_sh[3];
            v2 = s1_nbr_ff.right;
            n2 = win_sh[5];
         end
         gnms_pkg::SEC_DIAG: begin
            v1 = s1_nbr_ff.left & s1_nbr_ff.up;
            n1 = win_sh[0];
            v2 = s1_nbr_ff.right & s1_nbr_ff.down;
            n2 = win_sh[8];
         end
         gnms_pkg::SEC_VERT: begin
            v1 = s1_nbr_ff.up;
            n1 = win_sh[1];
            v2 = s1_nbr_ff.down;
            n2 = win_sh[7];
         end
         default: begin
            v1 = s1_nbr_ff.left & s1_nbr_ff.down;
            n1 = win_sh[6];
            v2 = s1_nbr_ff.right & s1_nbr_ff.up;
            n2 = win_sh[2];
         end
      endcase
   end

   assign suppress = (v1 && (n1 > centre)) || (v2 && (n2 > centre));

   always_comb begin
      if (suppress) begin
         result.edge_value = '0;
      end else if (centre[MAG_W-1 -: 4] != '0) begin
         result.edge_value = gnms_pkg::SAT_MAX;
      end else begin
         result.edge_value = centre[11:4];
      end
      result.frame_last = s1_last_ff;
   end

   // ---------------------------------------------------------------- queue
   assign push           = s1_v_ff & s1_emit_ff;
   assign rsp_valid      = qcnt_ff != '0;
   assign pop            = rsp_valid & ~rsp_stall;
   assign rsp_edge_value = q_ff[rptr_ff].edge_value;
   assign rsp_frame_last = q_ff[rptr_ff].frame_last;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(WID_RST);
         height_ff <= HGT_W'(gnms_pkg::HEIGHT_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
         s1_v_ff   <= 1'b0;
         centre_ff <= gnms_pkg::SEC_HORIZ;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
         wptr_ff   <= '0;
         rptr_ff   <= '0;
         qcnt_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_v_ff   <= take;
         if (csr_restart) begin
            centre_ff <= gnms_pkg::SEC_HORIZ;
            for (int i = 0; i < 9; i++) begin
               win_ff[i] <= '0;
            end
         end else if (s1_v_ff) begin
            centre_ff <= s1_last_ff ? gnms_pkg::SEC_HORIZ : sec_rd;
            for (int i = 0; i < 9; i++) begin
               win_ff[i] <= s1_last_ff ? '0 : win_sh[i];
            end
         end
         if (push) begin
            wptr_ff <= wptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + QPTR_W'(1);
         end
         qcnt_ff <= qcnt_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_col_ff  <= col_ff;
         s1_mag_ff  <= mag_now;
         s1_sec_ff  <= sec_now;
         s1_nbr_ff  <= nbr_now;
         s1_emit_ff <= emit_pos;
         s1_last_ff <= last_pos;
         s1_fwd_ff  <= fwd_hit;
      end
      if (s1_v_ff) begin
         wb_ff <= wr_word;
      end
      if (push) begin
         q_ff[wptr_ff] <= result;
      end
   end

endmodule
